// ===== hdl/vqr_pkg.sv =====
// ----------------------------------------------------------------------------
// vqr_pkg
// Types and constants shared by the voltage qualification rate monitor.
// ----------------------------------------------------------------------------
package vqr_pkg;

  localparam int PhaseCountDef    = 3;
  localparam int WindowSecondsDef = 60;
  localparam int StartupTicksDef  = 5;

  localparam logic [13:0] UpperReset     = 14'd2640;
  localparam logic [13:0] LowerReset     = 14'd1540;
  localparam logic [13:0] QualUpperReset = 14'd2354;
  localparam logic [13:0] QualLowerReset = 14'd2046;

  localparam logic [13:0] RateFull   = 14'd10000;
  localparam logic [19:0] SumMax     = 20'hFFFFF;
  localparam logic [10:0] DayCntMax  = 11'h7FF;
  localparam logic [15:0] MonCntMax  = 16'hFFFF;

  // Register indexes
  localparam logic [2:0] RegUpper     = 3'd0;
  localparam logic [2:0] RegLower     = 3'd1;
  localparam logic [2:0] RegQualUpper = 3'd2;
  localparam logic [2:0] RegQualLower = 3'd3;
  localparam logic [2:0] RegThreeWire = 3'd4;

  // Level codes
  localparam logic [2:0] LvlOverUpper = 3'd0;
  localparam logic [2:0] LvlOverQual  = 3'd1;
  localparam logic [2:0] LvlQual      = 3'd2;
  localparam logic [2:0] LvlUnderQual = 3'd3;
  localparam logic [2:0] LvlUnderLow  = 3'd4;

  typedef struct packed {
    logic [5:0]  clock_second;
    logic [5:0]  clock_minute;
    logic [4:0]  clock_hour;
    logic [4:0]  clock_day;
    logic [15:0] volt_a_bcd;
    logic [15:0] volt_b_bcd;
    logic [15:0] volt_c_bcd;
    logic        clear_daily;
    logic        clear_monthly;
  } vqr_in_t;

  typedef struct packed {
    logic [1:0]  phase_index;
    logic [2:0]  level_status;
    logic [13:0] day_pass_rate;
    logic [13:0] day_exceed_rate;
    logic [13:0] month_pass_rate;
    logic [13:0] month_exceed_rate;
    logic [10:0] day_above_minutes;
    logic [10:0] day_below_minutes;
    logic [15:0] month_above_minutes;
    logic [15:0] month_below_minutes;
    logic        last_of_tick;
  } vqr_out_t;

  // Four nibbles weighted as decimal digits, no digit check
  function automatic logic [15:0] bcd_value(input logic [15:0] v);
    logic [15:0] r;
    r = 16'(v[15:12]) * 16'd1000 + 16'(v[11:8]) * 16'd100
      + 16'(v[7:4]) * 16'd10 + 16'(v[3:0]);
    return r;
  endfunction

endpackage

// ===== hdl/voltage_qualification_rate_top.sv =====
// ----------------------------------------------------------------------------
// voltage_qualification_rate_top
// Per-phase voltage qualification monitor with day and month rates.
// ----------------------------------------------------------------------------
// Usage: one transfer on the in_ channel per one-second tick. A tick repeating
// the previous second, or one of the first STARTUP_TICKS ticks, gives no
// result and leaves in_ready high; any other tick gives PHASE_COUNT results
// on out_, phase 0 first, last_of_tick set on the final one. cfg_ writes are
// to be made by the user only while the block is idle; it does not enforce it.
// Sequence: each phase goes through one shared restoring divider: day rate
// (25 steps) and month rate (29 steps), plus the average (20 steps and a
// classify state) when the window closes, but not for phase 1 in three-wire
// mode. in_ready is low from acceptance until the last result transfer of
// the tick and returns the cycle after it.
// The result register holds its item while out_ready is low; the sequencer
// waits there. Reset (rst_n low, synchronous) restores the register defaults
// and zeroes all counters, sums and the second history.
// ----------------------------------------------------------------------------
module voltage_qualification_rate_top
  import vqr_pkg::*;
#(
  parameter int PHASE_COUNT    = PhaseCountDef,
  parameter int WINDOW_SECONDS = WindowSecondsDef,
  parameter int STARTUP_TICKS  = StartupTicksDef
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  vqr_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output vqr_out_t out_data,
  input  logic     cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [13:0] cfg_wdata
);

  localparam int PW = (PHASE_COUNT > 1) ? $clog2(PHASE_COUNT) : 1;
  localparam logic [2:0] StartupMax = 3'(STARTUP_TICKS);
  localparam logic [6:0] WindowLim  = 7'(WINDOW_SECONDS);

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_AVG, S_CLS, S_DLOAD, S_DAY, S_MON, S_OUT
  } state_t;

  state_t state_r;

  // configuration
  logic [13:0] upper_r, lower_r, qupper_r, qlower_r;
  logic        three_wire_r;

  // tick state
  logic [5:0]  prev_sec_r;
  logic [2:0]  startup_r;
  logic [5:0]  win_sec_r;
  logic [6:0]  samp_cnt_r;
  logic [19:0] vsum_r      [PHASE_COUNT];
  logic [10:0] day_above_r [PHASE_COUNT];
  logic [10:0] day_below_r [PHASE_COUNT];
  logic [15:0] mon_above_r [PHASE_COUNT];
  logic [15:0] mon_below_r [PHASE_COUNT];

  // per-tick latches
  vqr_in_t     tick_r;
  logic        closing_r;
  logic [7:0]  samples_r;
  logic [10:0] day_min_r;
  logic [15:0] mon_min_r;
  logic [PW-1:0] ph_r;
  logic [2:0]  lvl_r;
  logic [13:0] de_r;
  vqr_out_t    out_r;
  logic        out_valid_r;

  // shared restoring divider: dividend shifts out of dq_r, quotient bits in
  logic [28:0] dq_r;
  logic [15:0] drem_r;
  logic [15:0] dden_r;
  logic [4:0]  dcnt_r;

  logic [16:0] rem_sh;
  logic        rem_ge;
  logic [15:0] rem_nxt;
  logic [28:0] dq_nxt;
  always_comb begin
    rem_sh  = {drem_r, dq_r[28]};
    rem_ge  = rem_sh >= {1'b0, dden_r};
    rem_nxt = rem_ge ? 16'(rem_sh - {1'b0, dden_r}) : rem_sh[15:0];
    dq_nxt  = {dq_r[27:0], rem_ge};
  end

  // elapsed-time arithmetic for the accepted tick; bit 7 marks a negative gap
  logic [7:0]  elapsed;
  logic [7:0]  samples_nxt;
  logic        closing_nxt;
  logic [10:0] day_min_nxt;
  logic [15:0] mon_min_nxt;
  logic [4:0]  dday;
  always_comb begin
    elapsed = 8'(in_data.clock_second) - 8'(prev_sec_r) + 8'(win_sec_r);
    if (in_data.clock_second < prev_sec_r)
      elapsed = elapsed + 8'd60;
    samples_nxt = 8'(samp_cnt_r) + 8'd1;
    closing_nxt = elapsed[7] || (elapsed[6:0] >= WindowLim);
    day_min_nxt = 11'(in_data.clock_hour) * 11'd60 + 11'(in_data.clock_minute) + 11'd1;
    dday        = (in_data.clock_day != 5'd0) ? in_data.clock_day - 5'd1 : 5'd0;
    mon_min_nxt = 16'(day_min_nxt) + 16'(dday) * 16'd1440;
  end

  // current phase voltage, added to its sum with saturation
  logic [15:0] vbcd;
  logic [20:0] acc_sum;
  logic [19:0] acc_sat;
  always_comb begin
    case (ph_r)
      PW'(0):  vbcd = tick_r.volt_a_bcd;
      PW'(1):  vbcd = tick_r.volt_b_bcd;
      default: vbcd = tick_r.volt_c_bcd;
    endcase
    acc_sum = 21'(vsum_r[ph_r]) + 21'(bcd_value(vbcd));
    acc_sat = acc_sum[20] ? SumMax : acc_sum[19:0];
  end

  // classify the average left by the average pass
  logic [19:0] avg;
  logic [2:0]  lvl_cls;
  always_comb begin
    avg = dq_r[19:0];
    if (avg >= 20'(upper_r))       lvl_cls = LvlOverUpper;
    else if (avg >= 20'(qupper_r)) lvl_cls = LvlOverQual;
    else if (avg <= 20'(lower_r))  lvl_cls = LvlUnderLow;
    else if (avg <= 20'(qlower_r)) lvl_cls = LvlUnderQual;
    else                           lvl_cls = LvlQual;
  end

  // bad minute totals clamped to the monitored time, scaled for the rates
  logic [11:0] dbad;
  logic [16:0] mbad;
  logic [10:0] dbad_c;
  logic [15:0] mbad_c;
  logic [24:0] dprod;
  logic [28:0] mprod;
  always_comb begin
    dbad   = 12'(day_above_r[ph_r]) + 12'(day_below_r[ph_r]);
    mbad   = 17'(mon_above_r[ph_r]) + 17'(mon_below_r[ph_r]);
    dbad_c = (dbad > 12'(day_min_r)) ? day_min_r : dbad[10:0];
    mbad_c = (mbad > 17'(mon_min_r)) ? mon_min_r : mbad[15:0];
    dprod  = 25'(dbad_c) * 25'(RateFull);
    mprod  = 29'(mbad_c) * 29'(RateFull);
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // sequencer, registers and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      upper_r      <= UpperReset;
      lower_r      <= LowerReset;
      qupper_r     <= QualUpperReset;
      qlower_r     <= QualLowerReset;
      three_wire_r <= 1'b0;
      prev_sec_r   <= '0;
      startup_r    <= '0;
      win_sec_r    <= '0;
      samp_cnt_r   <= '0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < PHASE_COUNT; i++) begin
        vsum_r[i]      <= '0;
        day_above_r[i] <= '0;
        day_below_r[i] <= '0;
        mon_above_r[i] <= '0;
        mon_below_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          RegUpper:     upper_r      <= cfg_wdata;
          RegLower:     lower_r      <= cfg_wdata;
          RegQualUpper: qupper_r     <= cfg_wdata;
          RegQualLower: qlower_r     <= cfg_wdata;
          RegThreeWire: three_wire_r <= cfg_wdata[0];
          default: ;
        endcase
      end

      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            for (int i = 0; i < PHASE_COUNT; i++) begin
              if (in_data.clear_daily) begin
                day_above_r[i] <= '0;
                day_below_r[i] <= '0;
              end
              if (in_data.clear_monthly) begin
                mon_above_r[i] <= '0;
                mon_below_r[i] <= '0;
              end
            end
            if (in_data.clock_second != prev_sec_r) begin
              prev_sec_r <= in_data.clock_second;
              if (startup_r < StartupMax) begin
                startup_r <= startup_r + 3'd1;
              end else begin
                tick_r    <= in_data;
                closing_r <= closing_nxt;
                samples_r <= samples_nxt;
                day_min_r <= day_min_nxt;
                mon_min_r <= mon_min_nxt;
                if (closing_nxt) begin
                  win_sec_r  <= '0;
                  samp_cnt_r <= '0;
                end else begin
                  win_sec_r  <= elapsed[5:0];
                  samp_cnt_r <= samples_nxt[6:0];
                end
                ph_r    <= '0;
                state_r <= S_LOAD;
              end
            end
          end
        end
        S_LOAD: begin
          if (!closing_r) begin
            vsum_r[ph_r] <= acc_sat;
            lvl_r        <= LvlQual;
            state_r      <= S_DLOAD;
          end else if (three_wire_r && ph_r == PW'(1)) begin
            vsum_r[ph_r] <= '0;
            lvl_r        <= LvlQual;
            state_r      <= S_DLOAD;
          end else begin
            vsum_r[ph_r] <= '0;
            dq_r    <= {acc_sat, 9'd0};
            drem_r  <= '0;
            dden_r  <= 16'(samples_r);
            dcnt_r  <= 5'd19;
            state_r <= S_AVG;
          end
        end
        S_AVG: begin
          drem_r <= rem_nxt;
          dq_r   <= dq_nxt;
          dcnt_r <= dcnt_r - 5'd1;
          if (dcnt_r == 5'd0) state_r <= S_CLS;
        end
        S_CLS: begin
          // classify the average and bump the minute counters before the rates
          lvl_r <= lvl_cls;
          if (lvl_cls == LvlOverUpper || lvl_cls == LvlOverQual) begin
            if (day_above_r[ph_r] != DayCntMax) day_above_r[ph_r] <= day_above_r[ph_r] + 11'd1;
            if (mon_above_r[ph_r] != MonCntMax) mon_above_r[ph_r] <= mon_above_r[ph_r] + 16'd1;
          end else if (lvl_cls == LvlUnderQual || lvl_cls == LvlUnderLow) begin
            if (day_below_r[ph_r] != DayCntMax) day_below_r[ph_r] <= day_below_r[ph_r] + 11'd1;
            if (mon_below_r[ph_r] != MonCntMax) mon_below_r[ph_r] <= mon_below_r[ph_r] + 16'd1;
          end
          state_r <= S_DLOAD;
        end
        S_DLOAD: begin
          dq_r    <= {dprod, 4'd0};
          drem_r  <= '0;
          dden_r  <= 16'(day_min_r);
          dcnt_r  <= 5'd24;
          state_r <= S_DAY;
        end
        S_DAY: begin
          if (dcnt_r == 5'd0) begin
            de_r    <= dq_nxt[13:0];
            dq_r    <= mprod;
            drem_r  <= '0;
            dden_r  <= mon_min_r;
            dcnt_r  <= 5'd28;
            state_r <= S_MON;
          end else begin
            drem_r <= rem_nxt;
            dq_r   <= dq_nxt;
            dcnt_r <= dcnt_r - 5'd1;
          end
        end
        S_MON: begin
          if (dcnt_r == 5'd0) begin
            out_r.phase_index         <= 2'(ph_r);
            out_r.level_status        <= lvl_r;
            out_r.day_exceed_rate     <= de_r;
            out_r.day_pass_rate       <= RateFull - de_r;
            out_r.month_exceed_rate   <= dq_nxt[13:0];
            out_r.month_pass_rate     <= RateFull - dq_nxt[13:0];
            out_r.day_above_minutes   <= day_above_r[ph_r];
            out_r.day_below_minutes   <= day_below_r[ph_r];
            out_r.month_above_minutes <= mon_above_r[ph_r];
            out_r.month_below_minutes <= mon_below_r[ph_r];
            out_r.last_of_tick        <= (ph_r == PW'(PHASE_COUNT - 1));
            out_valid_r <= 1'b1;
            state_r     <= S_OUT;
          end else begin
            drem_r <= rem_nxt;
            dq_r   <= dq_nxt;
            dcnt_r <= dcnt_r - 5'd1;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            if (ph_r == PW'(PHASE_COUNT - 1)) begin
              state_r <= S_IDLE;
            end else begin
              ph_r    <= ph_r + PW'(1);
              state_r <= S_LOAD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sim/tb_voltage_qualification_rate_top.sv =====
// ----------------------------------------------------------------------------
// tb_voltage_qualification_rate_top
// Self-checking bench for the voltage qualification rate monitor: ticks are
// driven on the in_ channel, every accepted tick is run through a local
// copy of the monitoring behaviour, and each result transfer is checked
// field by field against the oldest predicted result.
// ----------------------------------------------------------------------------
module tb_voltage_qualification_rate_top;
  import vqr_pkg::*;

  localparam int WatchLimit  = 20000;
  localparam int DrainCycles = 400;

  // Tick model and store of predicted phase results
  class vqr_scoreboard;
    logic [13:0] upper, lower, qual_up, qual_lo;
    logic        three_wire;
    int unsigned prev_sec, boot_cnt, win_sec, n_samples;
    int unsigned vsum[3];
    int unsigned day_hi[3], day_lo[3], mon_hi[3], mon_lo[3];
    vqr_out_t    pending[$];
    int          errors;

    function void init();
      upper = UpperReset; lower = LowerReset;
      qual_up = QualUpperReset; qual_lo = QualLowerReset;
      three_wire = 1'b0;
      prev_sec = 0; boot_cnt = 0; win_sec = 0; n_samples = 0;
      for (int i = 0; i < 3; i++) begin
        vsum[i] = 0; day_hi[i] = 0; day_lo[i] = 0; mon_hi[i] = 0; mon_lo[i] = 0;
      end
      pending.delete();
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [13:0] val);
      case (idx)
        RegUpper:     upper = val;
        RegLower:     lower = val;
        RegQualUpper: qual_up = val;
        RegQualLower: qual_lo = val;
        RegThreeWire: three_wire = val[0];
        default: ;
      endcase
    endfunction

    function int unsigned decimal(logic [15:0] v);
      return v[15:12] * 1000 + v[11:8] * 100 + v[7:4] * 10 + v[3:0];
    endfunction

    function int unsigned out_of_range_rate(int unsigned bad, int unsigned total);
      if (total == 0) total = 1;
      if (bad > total) bad = total;
      return bad * 10000 / total;
    endfunction

    function void note_tick(vqr_in_t t);
      int unsigned gap, cnt, day_m, mon_m, acc, avg, de, me;
      logic [15:0] volts[3];
      logic [2:0]  lvl;
      bit          closing;
      vqr_out_t    r;
      volts[0] = t.volt_a_bcd; volts[1] = t.volt_b_bcd; volts[2] = t.volt_c_bcd;
      if (t.clear_daily)
        for (int i = 0; i < 3; i++) begin day_hi[i] = 0; day_lo[i] = 0; end
      if (t.clear_monthly)
        for (int i = 0; i < 3; i++) begin mon_hi[i] = 0; mon_lo[i] = 0; end
      if (t.clock_second == prev_sec) return;
      gap = (t.clock_second < prev_sec) ? t.clock_second + 60 - prev_sec
                                        : t.clock_second - prev_sec;
      prev_sec = t.clock_second;
      if (boot_cnt < 5) begin
        boot_cnt++;
        return;
      end
      gap += win_sec;
      cnt = n_samples + 1;
      closing = gap >= 60;
      if (closing) begin
        win_sec = 0; n_samples = 0;
      end else begin
        win_sec = gap & 63; n_samples = cnt & 127;
      end
      day_m = t.clock_hour * 60 + t.clock_minute + 1;
      mon_m = day_m + ((t.clock_day != 0) ? t.clock_day - 1 : 0) * 1440;
      for (int ph = 0; ph < 3; ph++) begin
        acc = vsum[ph] + decimal(volts[ph]);
        if (acc > 'hFFFFF) acc = 'hFFFFF;
        lvl = LvlQual;
        if (!closing) vsum[ph] = acc;
        else begin
          vsum[ph] = 0;
          if (!(three_wire && ph == 1)) begin
            avg = acc / cnt;
            if (avg >= upper) lvl = LvlOverUpper;
            else if (avg >= qual_up) lvl = LvlOverQual;
            else if (avg <= lower) lvl = LvlUnderLow;
            else if (avg <= qual_lo) lvl = LvlUnderQual;
          end
        end
        if (lvl == LvlOverUpper || lvl == LvlOverQual) begin
          if (day_hi[ph] < 'h7FF) day_hi[ph]++;
          if (mon_hi[ph] < 'hFFFF) mon_hi[ph]++;
        end else if (lvl == LvlUnderQual || lvl == LvlUnderLow) begin
          if (day_lo[ph] < 'h7FF) day_lo[ph]++;
          if (mon_lo[ph] < 'hFFFF) mon_lo[ph]++;
        end
        de = out_of_range_rate(day_hi[ph] + day_lo[ph], day_m);
        me = out_of_range_rate(mon_hi[ph] + mon_lo[ph], mon_m);
        r.phase_index         = ph[1:0];
        r.level_status        = lvl;
        r.day_pass_rate       = 14'(10000 - de);
        r.day_exceed_rate     = 14'(de);
        r.month_pass_rate     = 14'(10000 - me);
        r.month_exceed_rate   = 14'(me);
        r.day_above_minutes   = 11'(day_hi[ph]);
        r.day_below_minutes   = 11'(day_lo[ph]);
        r.month_above_minutes = 16'(mon_hi[ph]);
        r.month_below_minutes = 16'(mon_lo[ph]);
        r.last_of_tick        = (ph == 2);
        pending.push_back(r);
      end
    endfunction

    function void check_result(vqr_out_t got);
      vqr_out_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.phase_index !== exp.phase_index)
        $display("%0t: phase_index expected %0d actual %0d", $time,
                 exp.phase_index, got.phase_index);
      if (got.level_status !== exp.level_status)
        $display("%0t: level_status expected %0d actual %0d", $time,
                 exp.level_status, got.level_status);
      if (got.day_pass_rate !== exp.day_pass_rate)
        $display("%0t: day_pass_rate expected %0d actual %0d", $time,
                 exp.day_pass_rate, got.day_pass_rate);
      if (got.day_exceed_rate !== exp.day_exceed_rate)
        $display("%0t: day_exceed_rate expected %0d actual %0d", $time,
                 exp.day_exceed_rate, got.day_exceed_rate);
      if (got.month_pass_rate !== exp.month_pass_rate)
        $display("%0t: month_pass_rate expected %0d actual %0d", $time,
                 exp.month_pass_rate, got.month_pass_rate);
      if (got.month_exceed_rate !== exp.month_exceed_rate)
        $display("%0t: month_exceed_rate expected %0d actual %0d", $time,
                 exp.month_exceed_rate, got.month_exceed_rate);
      if (got.day_above_minutes !== exp.day_above_minutes)
        $display("%0t: day_above_minutes expected %0d actual %0d", $time,
                 exp.day_above_minutes, got.day_above_minutes);
      if (got.day_below_minutes !== exp.day_below_minutes)
        $display("%0t: day_below_minutes expected %0d actual %0d", $time,
                 exp.day_below_minutes, got.day_below_minutes);
      if (got.month_above_minutes !== exp.month_above_minutes)
        $display("%0t: month_above_minutes expected %0d actual %0d", $time,
                 exp.month_above_minutes, got.month_above_minutes);
      if (got.month_below_minutes !== exp.month_below_minutes)
        $display("%0t: month_below_minutes expected %0d actual %0d", $time,
                 exp.month_below_minutes, got.month_below_minutes);
      if (got.last_of_tick !== exp.last_of_tick)
        $display("%0t: last_of_tick expected %0d actual %0d", $time,
                 exp.last_of_tick, got.last_of_tick);
      if (got !== exp) errors++;
    endfunction
  endclass

  logic        clk, rst_n;
  logic        in_valid, in_ready, out_valid, out_ready;
  vqr_in_t     in_data;
  vqr_out_t    out_data;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [13:0] cfg_wdata;

  vqr_scoreboard sb;
  int  send_idle, recv_idle;   // idle chance in percent
  bit  hold_off, stim_done;
  int  quiet;
  int  sec_now;

  voltage_qualification_rate_top uut (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready,
    .out_data, .cfg_we, .cfg_index, .cfg_wdata
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Register write, only while idle; the caller drops cfg_we afterwards
  task automatic write_reg(logic [2:0] idx, logic [13:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic write_limits(int up, int lo, int qu, int ql, bit tw);
    write_reg(RegUpper, up[13:0]);
    write_reg(RegLower, lo[13:0]);
    write_reg(RegQualUpper, qu[13:0]);
    write_reg(RegQualLower, ql[13:0]);
    write_reg(RegThreeWire, {13'd0, tw});
    cfg_we <= 1'b0;
  endtask

  // One tick transfer with random idling before it; valid stays high after
  task automatic send_tick(vqr_in_t t);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    in_valid <= 1'b1; in_data <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_tick(t);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  function automatic logic [15:0] bcd_of(int v);
    return {4'(v / 1000 % 10), 4'(v / 100 % 10), 4'(v / 10 % 10), 4'(v % 10)};
  endfunction

  // Tick around a chosen level: mostly the next second, some jumps and repeats
  function automatic vqr_in_t next_tick(int base);
    vqr_in_t t;
    int      step;
    step = ($urandom_range(9) == 0) ? $urandom_range(1, 30) : 1;
    sec_now = (sec_now + step) % 60;
    t.clock_second  = sec_now[5:0];
    t.clock_minute  = 6'($urandom_range(59));
    t.clock_hour    = 5'($urandom_range(23));
    t.clock_day     = 5'($urandom_range(31));
    t.volt_a_bcd    = bcd_of(base + $urandom_range(0, 800) - 400);
    t.volt_b_bcd    = bcd_of(base + $urandom_range(0, 800) - 400);
    t.volt_c_bcd    = bcd_of(base + $urandom_range(0, 800) - 400);
    t.clear_daily   = ($urandom_range(49) == 0);
    t.clear_monthly = ($urandom_range(99) == 0);
    if ($urandom_range(9) == 0) t.volt_b_bcd = 16'($urandom);
    if ($urandom_range(19) == 0) t.clock_second = 6'($urandom);
    if ($urandom_range(19) == 0) t.clock_second = 6'(sb.prev_sec);   // repeat
    return t;
  endfunction

  task automatic random_phase(int n);
    int base;
    base = $urandom_range(1200, 2900);
    for (int i = 0; i < n; i++) begin
      if (i % 60 == 0) base = $urandom_range(1200, 2900);
      send_tick(next_tick(base));
    end
  endtask

  // Result side: random stalls, or a long hold-off when asked
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else if (hold_off) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_idle);
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  // Watchdog on cycles with no transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
    else if (!stim_done) quiet <= quiet + 1;
    if (quiet >= WatchLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    vqr_in_t t;
    sb = new();
    sb.init();
    rst_n = 1'b0; in_valid = 1'b0; in_data = '0; cfg_we = 1'b0;
    cfg_index = '0; cfg_wdata = '0; hold_off = 1'b0; stim_done = 1'b0;
    send_idle = 37; recv_idle = 67; sec_now = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: startup, repeats, extremes, clears, non-BCD digits, wrap
    for (int i = 0; i < 24; i++) begin
      t = '0;
      sec_now = (i == 3) ? sec_now : (sec_now + ((i == 12) ? 59 : 1)) % 60;
      t.clock_second = sec_now[5:0];
      t.clock_minute = (i % 2) ? 6'd59 : 6'd0;
      t.clock_hour   = (i % 3 == 0) ? 5'd23 : 5'd0;
      t.clock_day    = (i % 4 == 0) ? 5'd31 : 5'(i % 2);
      t.volt_a_bcd   = (i % 2) ? 16'hFFFF : 16'h0000;
      t.volt_b_bcd   = (i % 2) ? 16'h9999 : 16'h2200;
      t.volt_c_bcd   = bcd_of(1500 + i * 60);
      t.clear_daily  = (i == 9);
      t.clear_monthly = (i == 17);
      send_tick(t);
    end
    wait_drained();

    // Extreme limits: all zero with three-wire on, then all maximum with it off
    write_limits(0, 0, 0, 0, 1'b1);
    random_phase(70);
    wait_drained();
    write_limits(16383, 16383, 16383, 16383, 1'b0);
    random_phase(40);
    wait_drained();

    // Long receiver hold-off while ticks keep coming
    send_idle = 67; recv_idle = 37;
    write_limits(2640, 1540, 2354, 2046, 1'b1);
    fork
      begin
        hold_off = 1'b1;
        repeat (2000) @(posedge clk);
        hold_off = 1'b0;
      end
      random_phase(70);
    join
    wait_drained();

    send_idle = 0; recv_idle = 0;
    write_limits(9999, 0, 2500, 1800, 1'b0);
    random_phase(70);
    wait_drained();

    stim_done = 1'b1;
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
